FILE: design/fbpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and codes for the fixed block pool allocator: request and
// response words, function and status codes, register indexes and the
// controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package fbpa_pkg;

   localparam int unsigned ADDR_W  = 32;
   localparam int unsigned SHIFT_W = 5;
   localparam int unsigned COUNT_W = 9;
   localparam int unsigned FUNC_W  = 2;
   localparam int unsigned STAT_W  = 2;
   localparam int unsigned CSR_IDX_W = 2;

   // function codes
   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_INIT  = 2'd2;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STAT_PARAM = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BASE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SHIFT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_BLOCKS  = 2'd2;

   // reset values of the registers
   localparam logic [ADDR_W-1:0]  POOL_BASE_RST   = 32'd0;
   localparam logic [SHIFT_W-1:0] BLOCK_SHIFT_RST = 5'd4;
   localparam logic [COUNT_W-1:0] NUM_BLOCKS_RST  = 9'd256;

   localparam logic [COUNT_W-1:0] USED_MAX = 9'd511;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [ADDR_W-1:0] block_address;
   } req_word_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [ADDR_W-1:0]  alloc_address;
      logic [COUNT_W-1:0] used_count;
      logic [COUNT_W-1:0] free_space;
   } rsp_word_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;     // latch request, run free check, capture head link
      logic init_step;  // write one link of the init walk
      logic commit;     // update list state and load the response word
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [FUNC_W-1:0] func;  // function of the word at the request port
      logic n_zero;             // effective block count is zero
      logic init_last;          // init walk is on its last block
      logic out_free;           // response register can take a word
   } dp_sts_type;

endpackage

FILE: design/fbpa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Sequencer for the allocator: takes one request word at a time, runs the
// init link walk and holds the commit until the response register is free.
// ----------------------------------------------------------------------------
module fbpa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output fbpa_pkg::dp_cmd_type cmd,
   input  fbpa_pkg::dp_sts_type sts
);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_INIT   = 3'b010,
      S_COMMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (sts.func == fbpa_pkg::FUNC_INIT && !sts.n_zero) begin
                  state_in = S_INIT;
               end else begin
                  state_in = S_COMMIT;
               end
            end
         end
         S_INIT: begin
            cmd.init_step = 1'b1;
            if (sts.init_last) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // at most one datapath command per cycle
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.init_step, cmd.commit}))
      else $error("fbpa_ctrl: overlapping datapath commands");

   // an accepted word always leads into work
   a_accept_moves: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> (state_ff == S_INIT || state_ff == S_COMMIT))
      else $error("fbpa_ctrl: accepted word left idle");

   // request side is held off while a word is being worked on
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (cmd.init_step || cmd.commit) |-> req_stall)
      else $error("fbpa_ctrl: request open while busy");

endmodule

FILE: design/fbpa_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_datapath
// Configuration registers, link memory, free-list head, used count, free
// address check and the response register.
// ----------------------------------------------------------------------------
module fbpa_datapath #(
   parameter int unsigned POOL_DEPTH = 256
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_wr_en,
   input  logic [fbpa_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [fbpa_pkg::ADDR_W-1:0]              csr_wr_data,
   input  fbpa_pkg::req_word_type                   req_word,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output fbpa_pkg::rsp_word_type                   rsp_word,
   input  fbpa_pkg::dp_cmd_type                     cmd,
   output fbpa_pkg::dp_sts_type                     sts
);

   localparam int unsigned IW   = $clog2(POOL_DEPTH);
   localparam int unsigned CNTW = (IW > fbpa_pkg::COUNT_W) ? IW : fbpa_pkg::COUNT_W;
   localparam int unsigned LIMW = fbpa_pkg::ADDR_W + fbpa_pkg::COUNT_W;

   // link entry: {valid, next index}
   typedef logic [IW:0] link_type;

   // configuration
   logic [fbpa_pkg::ADDR_W-1:0]  pool_base_ff;
   logic [fbpa_pkg::SHIFT_W-1:0] block_shift_ff;
   logic [fbpa_pkg::COUNT_W-1:0] num_blocks_ff;
   logic [fbpa_pkg::COUNT_W-1:0] eff_n;

   // list state
   logic [IW-1:0]                head_ff, head_in;
   logic                         head_valid_ff, head_valid_in;
   logic [fbpa_pkg::COUNT_W-1:0] used_ff, used_in;

   // per-request registers
   fbpa_pkg::req_word_type       req_ff;
   logic                         free_err_ff;
   logic [IW-1:0]                free_idx_ff;
   logic [CNTW-1:0]              cnt_ff;

   // link memory
   link_type                     link_mem [POOL_DEPTH];
   link_type                     link_rd_ff;
   logic                         mem_we;
   logic [IW-1:0]                mem_waddr;
   link_type                     mem_wdata;

   // response register
   logic                         rsp_valid_ff;
   fbpa_pkg::rsp_word_type       rsp_ff, rsp_in;

   // free check
   logic [LIMW-1:0]              lim;
   logic [fbpa_pkg::ADDR_W-1:0]  diff;
   logic [fbpa_pkg::ADDR_W-1:0]  mask;
   logic                         chk_err;
   logic [IW-1:0]                chk_idx;

   logic [CNTW:0]                cnt_next;
   logic                         free_ok;

   // ---- configuration registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff   <= fbpa_pkg::POOL_BASE_RST;
         block_shift_ff <= fbpa_pkg::BLOCK_SHIFT_RST;
         num_blocks_ff  <= fbpa_pkg::NUM_BLOCKS_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            fbpa_pkg::CSR_POOL_BASE:   pool_base_ff   <= csr_wr_data;
            fbpa_pkg::CSR_BLOCK_SHIFT: block_shift_ff <= csr_wr_data[fbpa_pkg::SHIFT_W-1:0];
            fbpa_pkg::CSR_NUM_BLOCKS:  num_blocks_ff  <= csr_wr_data[fbpa_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // count capped at the memory depth
   assign eff_n = (32'(num_blocks_ff) > 32'(POOL_DEPTH)) ?
                  fbpa_pkg::COUNT_W'(POOL_DEPTH) : num_blocks_ff;

   // ---- free address check, on the incoming word ----
   assign lim     = LIMW'(pool_base_ff) + (LIMW'(eff_n) << block_shift_ff);
   assign diff    = req_word.block_address - pool_base_ff;
   assign mask    = ~({fbpa_pkg::ADDR_W{1'b1}} << block_shift_ff);
   assign chk_err = (req_word.block_address < pool_base_ff) ||
                    (LIMW'(req_word.block_address) >= lim) ||
                    ((diff & mask) != '0);
   assign chk_idx = IW'(diff >> block_shift_ff);

   // ---- init walk ----
   assign cnt_next = (CNTW + 1)'(cnt_ff) + (CNTW + 1)'(1);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff      <= req_word;
         free_err_ff <= chk_err;
         free_idx_ff <= chk_idx;
         cnt_ff      <= '0;
      end else if (cmd.init_step) begin
         cnt_ff <= cnt_next[CNTW-1:0];
      end
   end

   // ---- link memory ----
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = free_idx_ff;
      mem_wdata = {head_valid_ff, head_ff};
      if (cmd.init_step) begin
         mem_we    = 1'b1;
         mem_waddr = cnt_ff[IW-1:0];
         if (cnt_next < (CNTW + 1)'(eff_n)) begin
            mem_wdata = {1'b1, cnt_next[IW-1:0]};
         end else begin
            mem_wdata = '0;
         end
      end else if (cmd.commit && req_ff.func == fbpa_pkg::FUNC_FREE && !free_err_ff) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
      link_rd_ff <= link_mem[head_ff];
   end

   // ---- commit ----
   assign free_ok = (req_ff.func == fbpa_pkg::FUNC_FREE) && !free_err_ff;

   always_comb begin
      head_in              = head_ff;
      head_valid_in        = head_valid_ff;
      used_in              = used_ff;
      rsp_in.status        = fbpa_pkg::STAT_OK;
      rsp_in.alloc_address = '0;
      unique case (req_ff.func)
         fbpa_pkg::FUNC_INIT: begin
            head_in       = '0;
            head_valid_in = (eff_n != '0);
            used_in       = '0;
         end
         fbpa_pkg::FUNC_ALLOC: begin
            if (head_valid_ff) begin
               rsp_in.alloc_address = pool_base_ff +
                                      (fbpa_pkg::ADDR_W'(head_ff) << block_shift_ff);
               head_in       = link_rd_ff[IW-1:0];
               head_valid_in = link_rd_ff[IW];
               if (used_ff != fbpa_pkg::USED_MAX) begin
                  used_in = used_ff + fbpa_pkg::COUNT_W'(1);
               end
            end else begin
               rsp_in.status = fbpa_pkg::STAT_EMPTY;
            end
         end
         fbpa_pkg::FUNC_FREE: begin
            if (free_err_ff) begin
               rsp_in.status = fbpa_pkg::STAT_PARAM;
            end else begin
               head_in       = free_idx_ff;
               head_valid_in = 1'b1;
               if (used_ff != '0) begin
                  used_in = used_ff - fbpa_pkg::COUNT_W'(1);
               end
            end
         end
         default: ;
      endcase
      rsp_in.used_count = used_in;
      rsp_in.free_space = (eff_n > used_in) ? (eff_n - used_in) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         used_ff       <= '0;
      end else if (cmd.commit) begin
         head_valid_ff <= head_valid_in;
         used_ff       <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
      end else if (cmd.commit) begin
         head_ff <= head_in;
      end
   end

   // ---- response register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   assign sts.func      = req_word.func;
   assign sts.n_zero    = (eff_n == '0);
   assign sts.init_last = (cnt_next >= (CNTW + 1)'(eff_n));
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   // a commit always leaves a word in the response register
   a_commit_loads: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("fbpa_datapath: commit without response");

   // used count and free space add up to the block count while the used count is below it
   a_space_sum: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.used_count < eff_n) |->
         ((fbpa_pkg::COUNT_W + 1)'(rsp_ff.used_count) +
          (fbpa_pkg::COUNT_W + 1)'(rsp_ff.free_space) ==
          (fbpa_pkg::COUNT_W + 1)'(eff_n)))
      else $error("fbpa_datapath: free space inconsistent");

   // an accepted free leaves a non-empty list
   a_free_head: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && free_ok) |=> head_valid_ff)
      else $error("fbpa_datapath: list empty after free");

endmodule

FILE: design/fixed_block_pool_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Pool of equal power-of-two blocks managed through a LIFO free list held
// in a link memory. Allocate pops the head, free pushes a checked address,
// init relinks all blocks in ascending order.
// ----------------------------------------------------------------------------
//
//   channel   ports                         direction   word
//   --------  ----------------------------  ----------  ---------------------
//   request   req_valid/req_stall/req_word  in          func, block_address
//   response  rsp_valid/rsp_stall/rsp_word  out         status, address,
//                                                       used count, free space
//   config    csr_wr_en/csr_index/csr_wr_data in        base, size log2, count
//
// Allocate, free and unused codes run accept (free check,
// link read at the head), then commit (list update, response load).
// Init runs accept, one link write per block of the capped block count on
// the single write port, then commit; with a count of zero it skips the writes.
// Reset is synchronous; the list comes up empty, so no memory clearing pass.
// A stalled response holds the commit; the next request word is accepted
// while an earlier response still waits.
//
module fixed_block_pool_allocator #(
   parameter int unsigned POOL_DEPTH = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   // configuration writes
   input  logic                           csr_wr_en,
   input  logic [fbpa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fbpa_pkg::ADDR_W-1:0]    csr_wr_data,
   // request words
   input  logic                           req_valid,
   output logic                           req_stall,
   input  fbpa_pkg::req_word_type         req_word,
   // response words
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output fbpa_pkg::rsp_word_type         rsp_word
);

   // command and status groups between sequencer and datapath
   fbpa_pkg::dp_cmd_type cmd;
   fbpa_pkg::dp_sts_type sts;

   // sequencer: idle / init walk / commit
   fbpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // link memory, list head, counts and response register
   fbpa_datapath #(
      .POOL_DEPTH (POOL_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fixed block pool allocator. A predictor of the
// free list tracks every accepted request word and queues the response it
// should produce; a checker compares each accepted response word field by
// field. Directed tests cover the operations and pool corner cases, then
// random traffic runs under several register settings with random idling.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int unsigned POOL_SLOTS = 256;
   localparam logic [fbpa_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;  // unused code, no effect

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_wr_en = 1'b0;
   logic [fbpa_pkg::CSR_IDX_W-1:0] csr_index = fbpa_pkg::CSR_POOL_BASE;
   logic [fbpa_pkg::ADDR_W-1:0]    csr_wr_data = '0;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   fbpa_pkg::req_word_type         req_word = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   fbpa_pkg::rsp_word_type         rsp_word;

   fixed_block_pool_allocator #(
      .POOL_DEPTH(POOL_SLOTS)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word)
   );

   // ---------------------------------------------------------------------
   // Predictor state: register shadows and the free list itself.
   // ---------------------------------------------------------------------
   logic [fbpa_pkg::ADDR_W-1:0]  cfg_base  = fbpa_pkg::POOL_BASE_RST;
   logic [fbpa_pkg::SHIFT_W-1:0] cfg_shift = fbpa_pkg::BLOCK_SHIFT_RST;
   logic [fbpa_pkg::COUNT_W-1:0] cfg_count = fbpa_pkg::NUM_BLOCKS_RST;

   logic [7:0]                   link_next [POOL_SLOTS];
   logic                         link_live [POOL_SLOTS];
   logic [7:0]                   list_head = '0;
   logic                         list_live = 1'b0;  // list empty after reset
   logic [fbpa_pkg::COUNT_W-1:0] pred_used = '0;

   // Bench bookkeeping
   fbpa_pkg::req_word_type  pending_req [$];   // words waiting for the driver
   fbpa_pkg::rsp_word_type  expected_rsp [$];  // predicted responses, oldest first
   logic [31:0]   held_addr [$];     // allocated addresses, used to pick frees
   int            words_offered = 0;
   int            words_sent = 0;
   int            rsp_checked = 0;
   int            fail_count = 0;
   int            status_seen [4] = '{0, 0, 0, 0};
   int            rsp_hold_left = 0;  // long receiver hold-off, in cycles
   bit            quiet_run = 1'b0;   // no idling on either side

   initial begin
      forever #5 clock = ~clock;
   end

   // Block count as the block sees it: capped at the link memory depth.
   function automatic logic [fbpa_pkg::COUNT_W-1:0] eff_blocks();
      return (cfg_count > POOL_SLOTS) ? fbpa_pkg::COUNT_W'(POOL_SLOTS) : cfg_count;
   endfunction

   // Byte address of a block; formed in 32 bits, so it wraps.
   function automatic logic [31:0] block_addr_of(input logic [7:0] idx);
      return 32'(64'(cfg_base) + (64'(idx) << cfg_shift));
   endfunction

   // Applies one request word to the predicted list, returns its response.
   function automatic fbpa_pkg::rsp_word_type apply_pool_op(input fbpa_pkg::req_word_type w);
      fbpa_pkg::rsp_word_type       r;
      logic [fbpa_pkg::COUNT_W-1:0] n;
      logic [63:0]                  off;
      logic [63:0]                  lim;
      logic [63:0]                  mask;
      logic [7:0]                   h;
      r = '0;
      r.status = fbpa_pkg::STAT_OK;
      n = eff_blocks();
      case (w.func)
         fbpa_pkg::FUNC_INIT: begin
            // ascending chain, last block terminates the list
            for (int i = 0; i < n; i++) begin
               link_next[i] = 8'(i + 1);
               link_live[i] = (i + 1 < n);
            end
            list_head = '0;
            list_live = (n != 0);
            pred_used = '0;
         end
         fbpa_pkg::FUNC_ALLOC: begin
            if (list_live) begin
               h = list_head;
               r.alloc_address = block_addr_of(h);
               list_head = link_next[h];
               list_live = link_live[h];
               held_addr.push_back(r.alloc_address);
               if (pred_used != fbpa_pkg::USED_MAX) pred_used++;
            end else begin
               r.status = fbpa_pkg::STAT_EMPTY;
            end
         end
         fbpa_pkg::FUNC_FREE: begin
            // range check uses the unwrapped limit
            lim  = 64'(cfg_base) + (64'(n) << cfg_shift);
            mask = (64'd1 << cfg_shift) - 64'd1;
            off  = 64'(w.block_address) - 64'(cfg_base);
            if (w.block_address < cfg_base || 64'(w.block_address) >= lim ||
                (off & mask) != 0) begin
               r.status = fbpa_pkg::STAT_PARAM;
            end else begin
               // double frees go unnoticed: the block is pushed again
               h = 8'(off >> cfg_shift);
               link_next[h] = list_head;
               link_live[h] = list_live;
               list_head = h;
               list_live = 1'b1;
               if (pred_used != 0) pred_used--;
            end
         end
         default: ;
      endcase
      r.used_count = pred_used;
      r.free_space = (n > pred_used) ? n - pred_used : '0;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      fail_count++;
      $display("MISMATCH %s: got 0x%0h, predicted 0x%0h (t=%0t)", what, got, want,
               $time);
   endtask

   // ---------------------------------------------------------------------
   // Request driver: takes words from pending_req, predicts each one at the
   // edge it is accepted, and idles at random between words.
   // A stalled word is held as is.
   // ---------------------------------------------------------------------
   initial begin : req_driver
      int gap_left;
      gap_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && req_valid && !req_stall) begin
            expected_rsp.push_back(apply_pool_op(req_word));
            words_sent++;
         end
         if (!reset && !(req_valid && req_stall)) begin
            if (gap_left != 0) begin
               req_valid <= 1'b0;
               gap_left--;
            end else if (pending_req.size() != 0 &&
                         (quiet_run || $urandom_range(0, 5) != 0)) begin
               req_word  <= pending_req.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
               if (pending_req.size() != 0) gap_left = $urandom_range(0, 2);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response stall: a long hold-off when a test asks for one, otherwise
   // random stall bursts.
   // ---------------------------------------------------------------------
   initial begin : rsp_staller
      int burst_left;
      burst_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_left != 0) begin
            rsp_stall <= 1'b1;
            rsp_hold_left--;
         end else if (burst_left != 0) begin
            rsp_stall <= 1'b1;
            burst_left--;
         end else if (!quiet_run && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            burst_left = $urandom_range(0, 2);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response checker: every accepted word against the oldest prediction.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : rsp_check
      fbpa_pkg::rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("response word with none outstanding",
                            32'(rsp_word.status), 32'd0);
         end else begin
            want = expected_rsp.pop_front();
            rsp_checked++;
            status_seen[want.status]++;
            if (rsp_word.status !== want.status)
               report_mismatch("status", 32'(rsp_word.status), 32'(want.status));
            if (rsp_word.alloc_address !== want.alloc_address)
               report_mismatch("alloc_address", rsp_word.alloc_address, want.alloc_address);
            if (rsp_word.used_count !== want.used_count)
               report_mismatch("used_count", 32'(rsp_word.used_count),
                               32'(want.used_count));
            if (rsp_word.free_space !== want.free_space)
               report_mismatch("free_space", 32'(rsp_word.free_space),
                               32'(want.free_space));
         end
      end
   end

   // Queues one request word; keeps only a few ahead of the driver so that
   // free addresses are picked from fresh allocations.
   task automatic offer_word(input logic [fbpa_pkg::FUNC_W-1:0] func,
                             input logic [31:0] addr);
      fbpa_pkg::req_word_type w;
      w.func = func;
      w.block_address = addr;
      while (pending_req.size() >= 4) @(posedge clock);
      pending_req.push_back(w);
      words_offered++;
   endtask

   // Returns once every offered word is accepted and every response is in.
   task automatic wait_idle();
      while (words_sent != words_offered || expected_rsp.size() != 0) @(posedge clock);
   endtask

   // Writes all three registers, one per cycle; block must be idle.
   task automatic configure(input logic [31:0] base, input logic [4:0] shift,
                            input logic [8:0] count);
      cfg_base  = base;
      cfg_shift = shift;
      cfg_count = count;
      csr_wr_en   <= 1'b1;
      csr_index   <= fbpa_pkg::CSR_POOL_BASE;
      csr_wr_data <= base;
      @(posedge clock);
      csr_index   <= fbpa_pkg::CSR_BLOCK_SHIFT;
      csr_wr_data <= 32'(shift);
      @(posedge clock);
      csr_index   <= fbpa_pkg::CSR_NUM_BLOCKS;
      csr_wr_data <= 32'(count);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // An address the free check should mostly reject: misaligned, below
   // the base, right at the limit, or anything at all.
   function automatic logic [31:0] bad_free_address(input logic [31:0] a);
      logic [63:0] lim;
      logic [31:0] mask;
      logic [31:0] r;
      lim  = 64'(cfg_base) + (64'(eff_blocks()) << cfg_shift);
      mask = (32'd1 << cfg_shift) - 32'd1;
      r = a;
      case ($urandom_range(0, 3))
         0: if (cfg_shift != 0) r = block_addr_of(8'(a >> 24)) + ((a & mask) | 32'd1);
         1: if (cfg_base != 0) r = a % cfg_base;
         2: if (lim <= 64'hFFFF_FFFF) r = 32'(lim);
         default: ;
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset settings (base 0, 16-byte blocks, 256 blocks): each operation,
   // work before the first init, and the free checks.
   task automatic test_basic_ops();
      offer_word(fbpa_pkg::FUNC_ALLOC, 32'h0);          // nothing linked yet: empty
      offer_word(FUNC_SPARE, 32'h0);
      offer_word(fbpa_pkg::FUNC_FREE, 32'h0);           // used count stays at zero
      offer_word(fbpa_pkg::FUNC_ALLOC, 32'h0);          // pops the freed block
      offer_word(fbpa_pkg::FUNC_ALLOC, 32'h0);          // empty again
      offer_word(fbpa_pkg::FUNC_INIT, 32'hFFFF_FFFF);
      offer_word(fbpa_pkg::FUNC_ALLOC, 32'h0);
      offer_word(fbpa_pkg::FUNC_ALLOC, 32'h0);
      offer_word(fbpa_pkg::FUNC_FREE, 32'h10);
      offer_word(fbpa_pkg::FUNC_FREE, 32'h14);          // misaligned
      offer_word(fbpa_pkg::FUNC_FREE, 32'h1000);        // first address past the pool
      offer_word(fbpa_pkg::FUNC_FREE, 32'hFFFF_FFFF);
      offer_word(fbpa_pkg::FUNC_FREE, 32'hFF0);         // last block, never allocated
      offer_word(fbpa_pkg::FUNC_ALLOC, 32'h0);
      offer_word(fbpa_pkg::FUNC_ALLOC, 32'h0);
      offer_word(FUNC_SPARE, 32'hFFFF_FFFF);
      wait_idle();
   endtask

   // Register extremes: top-of-memory base, zero and over-range counts,
   // shifts of 0 and 31 with wrapping addresses.
   task automatic test_pool_edges();
      configure(32'hFFFF_FFFC, 5'd2, 9'd1);
      offer_word(fbpa_pkg::FUNC_INIT, 32'h0);
      offer_word(fbpa_pkg::FUNC_ALLOC, 32'h0);
      offer_word(fbpa_pkg::FUNC_ALLOC, 32'h0);
      offer_word(fbpa_pkg::FUNC_FREE, 32'h0);           // below base
      offer_word(fbpa_pkg::FUNC_FREE, 32'hFFFF_FFFC);
      offer_word(fbpa_pkg::FUNC_FREE, 32'hFFFF_FFFC);   // double free links block to itself
      offer_word(fbpa_pkg::FUNC_ALLOC, 32'h0);
      offer_word(fbpa_pkg::FUNC_ALLOC, 32'h0);
      wait_idle();

      configure(32'h0, 5'd31, 9'd0);          // no blocks at all
      offer_word(fbpa_pkg::FUNC_INIT, 32'h0);
      offer_word(fbpa_pkg::FUNC_ALLOC, 32'h0);
      offer_word(fbpa_pkg::FUNC_FREE, 32'h0);
      wait_idle();

      configure(32'h0, 5'd31, 9'd511);        // count capped at 256
      offer_word(fbpa_pkg::FUNC_INIT, 32'h0);
      offer_word(fbpa_pkg::FUNC_ALLOC, 32'h0);
      offer_word(fbpa_pkg::FUNC_ALLOC, 32'h0);
      offer_word(fbpa_pkg::FUNC_ALLOC, 32'h0);          // address wraps to zero
      offer_word(fbpa_pkg::FUNC_FREE, 32'h8000_0000);
      offer_word(fbpa_pkg::FUNC_FREE, 32'h4000_0000);
      wait_idle();

      configure(32'h5, 5'd0, 9'd3);           // one-byte blocks
      offer_word(fbpa_pkg::FUNC_INIT, 32'h0);
      offer_word(fbpa_pkg::FUNC_FREE, 32'h4);
      offer_word(fbpa_pkg::FUNC_ALLOC, 32'h0);
      offer_word(fbpa_pkg::FUNC_FREE, 32'h7);
      offer_word(fbpa_pkg::FUNC_FREE, 32'h8);
      wait_idle();
   endtask

   // Register writes do not relink: linked indices stay, addresses follow
   // the new base and size.
   task automatic test_reconfig_keeps_links();
      configure(32'h1000, 5'd4, 9'd4);
      offer_word(fbpa_pkg::FUNC_INIT, 32'h0);
      offer_word(fbpa_pkg::FUNC_ALLOC, 32'h0);
      wait_idle();
      configure(32'h2000, 5'd8, 9'd2);
      offer_word(fbpa_pkg::FUNC_ALLOC, 32'h0);
      offer_word(fbpa_pkg::FUNC_FREE, 32'h2000);
      offer_word(fbpa_pkg::FUNC_FREE, 32'h2200);        // beyond the shrunk pool
      offer_word(fbpa_pkg::FUNC_ALLOC, 32'h0);
      offer_word(fbpa_pkg::FUNC_ALLOC, 32'h0);          // index 2, still linked
      wait_idle();
   endtask

   // Used count: floor at zero on free, ceiling at 511 on alloc. A double
   // free makes the list endless, so allocs keep succeeding.
   task automatic test_used_saturation();
      configure(32'h100, 5'd3, 9'd2);
      offer_word(fbpa_pkg::FUNC_INIT, 32'h0);
      offer_word(fbpa_pkg::FUNC_ALLOC, 32'h0);
      offer_word(fbpa_pkg::FUNC_ALLOC, 32'h0);
      repeat (3) offer_word(fbpa_pkg::FUNC_FREE, 32'h100);
      repeat (515) offer_word(fbpa_pkg::FUNC_ALLOC, $urandom());
      repeat (2) offer_word(fbpa_pkg::FUNC_FREE, 32'h108);
      wait_idle();
   endtask

   // Receiver holds off long enough for the block to fill and stall its
   // request side; then the sender pauses until all responses are in.
   task automatic test_backpressure();
      configure(32'h4000, 5'd5, 9'd16);
      offer_word(fbpa_pkg::FUNC_INIT, 32'h0);
      rsp_hold_left = 150;
      for (int k = 0; k < 10; k++) offer_word(fbpa_pkg::FUNC_ALLOC, $urandom());
      for (int k = 0; k < 6; k++) offer_word(fbpa_pkg::FUNC_FREE, 32'h4000 + 32'(k << 5));
      wait_idle();
      repeat (4) offer_word(fbpa_pkg::FUNC_ALLOC, $urandom());
      wait_idle();
      repeat (4) offer_word(fbpa_pkg::FUNC_FREE, 32'h4000 + ($urandom_range(0, 15) << 5));
      wait_idle();
   endtask

   // Random traffic in phases, each with its own settings and an init.
   // Mostly allocs and frees of held blocks; the rest are stray frees,
   // bad addresses, the unused code and re-inits. Last phase runs without
   // idling on either side.
   task automatic test_random_traffic();
      int          pick;
      int          sel;
      int          idx;
      logic [8:0]  cnt;
      logic [8:0]  n;
      logic [31:0] a;
      for (int p = 0; p < 8; p++) begin
         wait_idle();
         quiet_run = (p == 7);
         sel = $urandom_range(0, 9);
         cnt = (sel < 5) ? 9'($urandom_range(1, 12)) :
               (sel < 8) ? 9'($urandom_range(13, 64)) : 9'd256;
         case (p)
            0: configure($urandom() & 32'hFFFF_FFFC, 5'd4, 9'd8);
            1: configure(32'h0, 5'd2, 9'd256);
            2: configure(32'hFFFF_FFFC, 5'd16, 9'd1);
            default: configure($urandom() & 32'hFFFF_FFFC, 5'($urandom_range(2, 16)), cnt);
         endcase
         held_addr.delete();
         offer_word(fbpa_pkg::FUNC_INIT, $urandom());
         n = eff_blocks();
         for (int k = 0; k < 50; k++) begin
            pick = $urandom_range(0, 99);
            a = $urandom();
            if (pick < 45) begin
               offer_word(fbpa_pkg::FUNC_ALLOC, a);
            end else if (pick < 72 && held_addr.size() != 0) begin
               idx = $urandom_range(0, held_addr.size() - 1);
               a = held_addr[idx];
               held_addr.delete(idx);
               offer_word(fbpa_pkg::FUNC_FREE, a);
            end else if (pick < 80 && n != 0) begin
               offer_word(fbpa_pkg::FUNC_FREE, block_addr_of(8'($urandom_range(0, n - 1))));
            end else if (pick < 92) begin
               offer_word(fbpa_pkg::FUNC_FREE, bad_free_address(a));
            end else if (pick < 96) begin
               offer_word(FUNC_SPARE, a);
            end else if (pick < 98) begin
               offer_word(fbpa_pkg::FUNC_INIT, a);
            end else begin
               offer_word(fbpa_pkg::FUNC_ALLOC, a);
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_basic_ops();
      test_pool_edges();
      test_reconfig_keeps_links();
      test_used_saturation();
      test_backpressure();
      test_random_traffic();
      wait_idle();
      // let any stray response show up
      repeat (20) @(posedge clock);
      $display("Run: %0d request words, %0d responses checked (ok %0d, empty %0d, param %0d)",
               words_sent, rsp_checked, status_seen[fbpa_pkg::STAT_OK],
               status_seen[fbpa_pkg::STAT_EMPTY], status_seen[fbpa_pkg::STAT_PARAM]);
      $display("Swept base/size/count extremes, zero and capped counts; %0d mismatches",
               fail_count);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #2ms;
      $display("TIMEOUT: %0d words offered, %0d accepted, %0d responses outstanding",
               words_offered, words_sent, expected_rsp.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule
